// ----- rtl/idcf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_pkg
// Shared widths, constants and lookup functions for the IMU deadband
// complementary filter.
// ----------------------------------------------------------------------------
package idcf_pkg;

    localparam int DIV_NUM_W       = 42;
    localparam int DIV_DEN_W       = 19;
    localparam int SAT_IN_W        = 43;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int CORDIC_XY_W      = 34;
    localparam int CORDIC_Z_W       = 27;
    localparam int CORDIC_RES_W     = 20;
    localparam int CORDIC_PRESHIFT  = 14;
    localparam logic signed [CORDIC_Z_W-1:0] HALF_TURN = 27'sd11796480;

    localparam int ACCEL_G_SHIFT = 12;
    localparam int GYRO_SHIFT    = 8;
    localparam logic [6:0]  GYRO_DEN_SCALE = 7'd100;
    localparam logic [5:0]  BLEND_OLD      = 6'd49;
    localparam logic [17:0] MAG_LO = 18'd8192;
    localparam logic [17:0] MAG_HI = 18'd32768;

    // divide by 50 as two 16-bit digits through a reciprocal multiply
    localparam int          BLEND_MAG_W     = 37;
    localparam int          BLEND_RCP_SHIFT = 28;
    localparam logic [5:0]  BLEND_DEN       = 6'd50;
    localparam logic [4:0]  BLEND_HALF      = 5'd25;
    localparam logic [22:0] BLEND_RCP       = 23'd5368710;

    localparam logic [11:0] GYRO_SCALE_RST  = 12'd164;
    localparam logic [15:0] ACCEL_SCALE_RST = 16'd16384;
    localparam logic [15:0] GYRO_DB_RST     = 16'd0;
    localparam logic [15:0] ACCEL_DB_RST    = 16'd130;
    localparam logic [15:0] TICK_WRAP_RST   = 16'd65535;

    typedef enum logic [2:0] {
        REG_GYRO_SCALE  = 3'd0,
        REG_ACCEL_SCALE = 3'd1,
        REG_GYRO_DB     = 3'd2,
        REG_ACCEL_DB    = 3'd3,
        REG_TICK_WRAP   = 3'd4
    } cfg_reg_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [CORDIC_Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
        logic signed [CORDIC_Z_W-1:0] r;
        case (i)
            5'd0:    r = 27'sd2949120;
            5'd1:    r = 27'sd1740967;
            5'd2:    r = 27'sd919879;
            5'd3:    r = 27'sd466945;
            5'd4:    r = 27'sd234379;
            5'd5:    r = 27'sd117304;
            5'd6:    r = 27'sd58666;
            5'd7:    r = 27'sd29335;
            5'd8:    r = 27'sd14668;
            5'd9:    r = 27'sd7334;
            5'd10:   r = 27'sd3667;
            5'd11:   r = 27'sd1833;
            5'd12:   r = 27'sd917;
            5'd13:   r = 27'sd458;
            5'd14:   r = 27'sd229;
            5'd15:   r = 27'sd115;
            5'd16:   r = 27'sd57;
            5'd17:   r = 27'sd29;
            5'd18:   r = 27'sd14;
            5'd19:   r = 27'sd7;
            5'd20:   r = 27'sd4;
            5'd21:   r = 27'sd2;
            5'd22:   r = 27'sd1;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[SAT_IN_W-1:31]) || !(|v[SAT_IN_W-1:31]))
            r = v[31:0];
        else if (v[SAT_IN_W-1])
            r = 32'sh80000000;
        else
            r = 32'sh7fffffff;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/idcf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_div
// Shared restoring divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero.
// ----------------------------------------------------------------------------
module idcf_div
    import idcf_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output      logic                    done,
    output      logic signed [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        mag   = (num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num)) + NUM_W'(den >> 1);
        trial = {rem_reg, q_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            neg_reg <= num[NUM_W-1];
            q_reg   <= mag;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

// ----- rtl/idcf_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_cordic
// Iterative CORDIC vectoring unit giving atan2(y, x) in 1/256 degree, one
// rotation per cycle.
// ----------------------------------------------------------------------------
module idcf_cordic
    import idcf_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [15:0]             y_in,
    input  wire logic signed [15:0]             x_in,
    output      logic                           done,
    output      logic signed [CORDIC_RES_W-1:0] angle
);

    localparam int NSTEPS = (STEPS > ATAN_DEPTH) ? ATAN_DEPTH : STEPS;

    logic                          busy_reg;
    logic                          done_reg;
    logic [ATAN_IDX_W-1:0]         step_reg;
    logic signed [CORDIC_XY_W-1:0] x_reg;
    logic signed [CORDIC_XY_W-1:0] y_reg;
    logic signed [CORDIC_Z_W-1:0]  z_reg;

    logic signed [CORDIC_XY_W-1:0] x0;
    logic signed [CORDIC_XY_W-1:0] y0;
    logic signed [CORDIC_XY_W-1:0] xs;
    logic signed [CORDIC_XY_W-1:0] ys;
    logic signed [CORDIC_Z_W-1:0]  at;
    logic        [CORDIC_Z_W-1:0]  zabs;
    logic        [CORDIC_Z_W-1:0]  zr;
    logic                          zero_in;

    always_comb
    begin
        x0      = {{(CORDIC_XY_W-16-CORDIC_PRESHIFT){x_in[15]}}, x_in, {CORDIC_PRESHIFT{1'b0}}};
        y0      = {{(CORDIC_XY_W-16-CORDIC_PRESHIFT){y_in[15]}}, y_in, {CORDIC_PRESHIFT{1'b0}}};
        zero_in = (x_in == 16'sd0) && (y_in == 16'sd0);
        xs      = x_reg >>> step_reg;
        ys      = y_reg >>> step_reg;
        at      = atan_lut(step_reg);
        zabs    = z_reg[CORDIC_Z_W-1] ? CORDIC_Z_W'(-z_reg) : CORDIC_Z_W'(z_reg);
        zr      = (zabs + CORDIC_Z_W'(128)) >> 8;
        angle   = z_reg[CORDIC_Z_W-1] ? -$signed(CORDIC_RES_W'(zr))
                                      : $signed(CORDIC_RES_W'(zr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                step_reg <= '0;
                if (zero_in)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == ATAN_IDX_W'(NSTEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            if (zero_in)
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
            else if (x_in[15])
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= y_in[15] ? -HALF_TURN : HALF_TURN;
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/imu_deadband_complementary_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imu_deadband_complementary_filter
// Pitch/roll complementary filter with per-axis deadband on six-axis samples.
// ----------------------------------------------------------------------------
// One sample word is taken at a time; s_tready stays low until its result is
// built. Each updated accel axis is scaled, and the two gyro integrations
// follow, all in one shared 42-step restoring divider. When the accel
// magnitude is in range, each of the two blends runs an atan2 on the
// iterative CORDIC unit, then a reciprocal multiply for the divide by 50.
// A finished result waits in an output register, so the next sample is taken
// while it is still pending; a result not yet taken when the next one is
// done holds the block until it leaves.
// ----------------------------------------------------------------------------
module imu_deadband_complementary_filter
    import idcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, tick_ms
    input  wire logic [111:0] s_tdata,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // interval_ms, held_gyro_x/y/z, held_accel_x/y/z, vib_x/y/z_g,
    // pitch_angle, roll_angle
    output      logic [271:0] m_tdata,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AG_START,
        S_AG_WAIT,
        S_GY_MUL,
        S_GY_START,
        S_GY_WAIT,
        S_CHECK,
        S_COR_START,
        S_COR_WAIT,
        S_BL_START,
        S_BL_HI,
        S_BL_REM,
        S_BL_LO,
        S_BL_DONE,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [11:0] gyro_scale_reg;
    logic [15:0] accel_scale_reg;
    logic [15:0] gyro_db_reg;
    logic [15:0] accel_db_reg;
    logic [15:0] tick_wrap_reg;

    logic signed [15:0] held_gyro_reg [3];
    logic signed [15:0] held_accel_reg [3];
    logic signed [31:0] held_g_reg [3];
    logic [15:0]        prev_tick_reg;
    logic signed [31:0] pitch_reg;
    logic signed [31:0] roll_reg;

    logic [15:0]                    interval_reg;
    logic [2:0]                     upd_reg;
    logic [1:0]                     ax_reg;
    logic signed [32:0]             prod_reg;
    logic signed [CORDIC_RES_W-1:0] acc_reg;

    logic                   bl_neg_reg;
    logic [BLEND_MAG_W-1:0] bl_mag_reg;
    logic [15:0]            bl_qhi_reg;
    logic [5:0]             bl_rem_reg;
    logic [15:0]            bl_qlo_reg;

    logic         m_tvalid_reg;
    logic [271:0] out_data_reg;

    logic                        div_start;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0]        div_den;
    logic                        div_done;
    logic signed [DIV_NUM_W-1:0] div_quo;

    logic                           cor_start;
    logic signed [15:0]             cor_y;
    logic                           cor_done;
    logic signed [CORDIC_RES_W-1:0] cor_angle;

    logic signed [15:0] in_gyro [3];
    logic signed [15:0] in_accel [3];
    logic [15:0]        in_tick;
    logic [15:0]        interval;
    logic [11:0]        gsens;
    logic [15:0]        asens;
    logic [DIV_DEN_W-1:0] gden;
    logic signed [16:0] dg [3];
    logic signed [16:0] da [3];
    logic [16:0]        adg [3];
    logic [16:0]        ada [3];
    logic [16:0]        aha [3];
    logic [17:0]        mag;
    logic signed [31:0] ang_sel;
    logic signed [DIV_NUM_W-1:0] blend_num;
    logic [DIV_NUM_W-1:0]        blend_abs;
    logic [21:0]                 rcp_op;
    logic [44:0]                 rcp_prod;
    logic [31:0]                 bl_quo;
    logic signed [SAT_IN_W-1:0]  gy_sum;
    logic signed [SAT_IN_W-1:0]  bl_val;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_gyro[k]  = s_tdata[16*k +: 16];
            in_accel[k] = s_tdata[48 + 16*k +: 16];
            dg[k]  = {in_gyro[k][15], in_gyro[k]} - {held_gyro_reg[k][15], held_gyro_reg[k]};
            da[k]  = {in_accel[k][15], in_accel[k]} - {held_accel_reg[k][15], held_accel_reg[k]};
            adg[k] = dg[k][16] ? 17'(-dg[k]) : 17'(dg[k]);
            ada[k] = da[k][16] ? 17'(-da[k]) : 17'(da[k]);
            aha[k] = held_accel_reg[k][15] ? 17'(-{held_accel_reg[k][15], held_accel_reg[k]})
                                           : {1'b0, held_accel_reg[k]};
        end
        in_tick  = s_tdata[111:96];
        interval = (in_tick >= prev_tick_reg) ? in_tick - prev_tick_reg
                                              : in_tick + tick_wrap_reg - prev_tick_reg;
        gsens    = (gyro_scale_reg == 12'd0) ? 12'd1 : gyro_scale_reg;
        asens    = (accel_scale_reg == 16'd0) ? 16'd1 : accel_scale_reg;
        gden     = DIV_DEN_W'(gsens * GYRO_DEN_SCALE);
        mag      = 18'(aha[0]) + 18'(aha[1]) + 18'(aha[2]);
        ang_sel  = (ax_reg == 2'd0) ? pitch_reg : roll_reg;
        blend_num = {{(DIV_NUM_W-32){ang_sel[31]}}, ang_sel} * $signed({1'b0, BLEND_OLD})
                  + {{(DIV_NUM_W-CORDIC_RES_W){acc_reg[CORDIC_RES_W-1]}}, acc_reg};
        blend_abs = blend_num[DIV_NUM_W-1] ? DIV_NUM_W'(-blend_num) : DIV_NUM_W'(blend_num);
        rcp_op   = (state_reg == S_BL_HI) ? 22'(bl_mag_reg[BLEND_MAG_W-1:16])
                                          : {bl_rem_reg, bl_mag_reg[15:0]};
        rcp_prod = rcp_op * BLEND_RCP;
        bl_quo   = {bl_qhi_reg, bl_qlo_reg};
        gy_sum   = (ax_reg == 2'd0)
                 ? {{(SAT_IN_W-32){pitch_reg[31]}}, pitch_reg} + SAT_IN_W'(div_quo)
                 : {{(SAT_IN_W-32){roll_reg[31]}}, roll_reg} - SAT_IN_W'(div_quo);
        bl_val   = bl_neg_reg ? -SAT_IN_W'(bl_quo) : SAT_IN_W'(bl_quo);
        cor_y    = (ax_reg == 2'd0) ? held_accel_reg[1] : held_accel_reg[0];

        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        cor_start = 1'b0;
        case (state_reg)
            S_AG_START:
            begin
                div_start = upd_reg[ax_reg];
                div_num   = {{(DIV_NUM_W-16-ACCEL_G_SHIFT){held_accel_reg[ax_reg][15]}},
                             held_accel_reg[ax_reg], {ACCEL_G_SHIFT{1'b0}}};
                div_den   = DIV_DEN_W'(asens);
            end
            S_GY_START:
            begin
                div_start = 1'b1;
                div_num   = {{(DIV_NUM_W-33-GYRO_SHIFT){prod_reg[32]}}, prod_reg,
                             {GYRO_SHIFT{1'b0}}};
                div_den   = gden;
            end
            S_COR_START: cor_start = 1'b1;
            default: ;
        endcase
    end

    idcf_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    idcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (held_accel_reg[2]),
        .done  (cor_done),
        .angle (cor_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_scale_reg  <= GYRO_SCALE_RST;
            accel_scale_reg <= ACCEL_SCALE_RST;
            gyro_db_reg     <= GYRO_DB_RST;
            accel_db_reg    <= ACCEL_DB_RST;
            tick_wrap_reg   <= TICK_WRAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_data[11:0];
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                REG_GYRO_DB:     gyro_db_reg     <= cfg_data;
                REG_ACCEL_DB:    accel_db_reg    <= cfg_data;
                REG_TICK_WRAP:   tick_wrap_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            prev_tick_reg <= '0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            ax_reg        <= '0;
            for (int k = 0; k < 3; k++)
            begin
                held_gyro_reg[k]  <= '0;
                held_accel_reg[k] <= '0;
                held_g_reg[k]     <= '0;
            end
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        prev_tick_reg <= in_tick;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (adg[k] > {1'b0, gyro_db_reg})
                                held_gyro_reg[k] <= in_gyro[k];
                            if (ada[k] > {1'b0, accel_db_reg})
                                held_accel_reg[k] <= in_accel[k];
                        end
                        ax_reg    <= '0;
                        state_reg <= S_AG_START;
                    end
                end
                S_AG_START:
                begin
                    if (upd_reg[ax_reg])
                        state_reg <= S_AG_WAIT;
                    else if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_GY_MUL;
                    end
                    else
                        ax_reg <= ax_reg + 1'b1;
                end
                S_AG_WAIT:
                begin
                    if (div_done)
                    begin
                        held_g_reg[ax_reg] <= div_quo[31:0];
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_GY_MUL;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_AG_START;
                        end
                    end
                end
                S_GY_MUL:   state_reg <= S_GY_START;
                S_GY_START: state_reg <= S_GY_WAIT;
                S_GY_WAIT:
                begin
                    if (div_done)
                    begin
                        if (ax_reg == 2'd0)
                        begin
                            pitch_reg <= sat32(gy_sum);
                            ax_reg    <= 2'd1;
                            state_reg <= S_GY_MUL;
                        end
                        else
                        begin
                            roll_reg  <= sat32(gy_sum);
                            ax_reg    <= '0;
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                    state_reg <= (mag > MAG_LO && mag < MAG_HI) ? S_COR_START : S_OUT;
                S_COR_START: state_reg <= S_COR_WAIT;
                S_COR_WAIT:
                begin
                    if (cor_done)
                        state_reg <= S_BL_START;
                end
                S_BL_START: state_reg <= S_BL_HI;
                S_BL_HI:    state_reg <= S_BL_REM;
                S_BL_REM:   state_reg <= S_BL_LO;
                S_BL_LO:    state_reg <= S_BL_DONE;
                S_BL_DONE:
                begin
                    if (ax_reg == 2'd0)
                    begin
                        pitch_reg <= sat32(bl_val);
                        ax_reg    <= 2'd1;
                        state_reg <= S_COR_START;
                    end
                    else
                    begin
                        roll_reg  <= sat32(bl_val);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            interval_reg <= interval;
            for (int k = 0; k < 3; k++)
                upd_reg[k] <= ada[k] > {1'b0, accel_db_reg};
        end
        if (state_reg == S_GY_MUL)
            prod_reg <= ((ax_reg == 2'd0) ? held_gyro_reg[0] : held_gyro_reg[1])
                      * $signed({1'b0, interval_reg});
        if (state_reg == S_COR_WAIT && cor_done)
            acc_reg <= cor_angle;
        if (state_reg == S_BL_START)
        begin
            bl_neg_reg <= blend_num[DIV_NUM_W-1];
            bl_mag_reg <= BLEND_MAG_W'(blend_abs) + BLEND_MAG_W'(BLEND_HALF);
        end
        if (state_reg == S_BL_HI)
            bl_qhi_reg <= rcp_prod[BLEND_RCP_SHIFT +: 16];
        if (state_reg == S_BL_REM)
            bl_rem_reg <= 6'(bl_mag_reg[BLEND_MAG_W-1:16] - 21'(bl_qhi_reg * BLEND_DEN));
        if (state_reg == S_BL_LO)
            bl_qlo_reg <= rcp_prod[BLEND_RCP_SHIFT +: 16];
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
            out_data_reg <= {roll_reg, pitch_reg,
                             held_g_reg[2], held_g_reg[1], held_g_reg[0],
                             held_accel_reg[2], held_accel_reg[1], held_accel_reg[0],
                             held_gyro_reg[2], held_gyro_reg[1], held_gyro_reg[0],
                             interval_reg};
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
